FILE: design/bpc_pkg.sv
// bpc_pkg: shared types and constants for the button press classifier.
// Holds field widths, register indexes, reset values, sleep cause codes
// and the per-lane status and result structs. No dependencies.
`default_nettype none

package bpc_pkg;

	localparam int TIME_W    = 32;
	localparam int MASK_W    = 7;
	localparam int LONG_W    = 6;
	localparam int CAUSE_W   = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_HOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_SLEEP = 2'd2;

	localparam logic [TIME_W-1:0] LONG_PRESS_RST = 32'd1000;
	localparam logic [TIME_W-1:0] POWER_HOLD_RST = 32'd3000;
	localparam logic [TIME_W-1:0] IDLE_SLEEP_RST = 32'd0;

	localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_POWER = 2'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_IDLE  = 2'd2;

	typedef struct packed {
		logic short_hit;
		logic long_hit;
		logic activity;
	} lane_status_t;

	typedef struct packed {
		logic [MASK_W-1:0]  short_press_mask;
		logic [LONG_W-1:0]  long_press_mask;
		logic               sleep_request;
		logic [CAUSE_W-1:0] sleep_cause;
	} result_t;

endpackage

`default_nettype wire

FILE: design/bpc_lane.sv
// bpc_lane: per-button press tracker: start time, long-fired mark and the
// short/long classification for one beat. Depends on bpc_pkg.
`default_nettype none

module bpc_lane (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            upd,
	input  wire logic [bpc_pkg::TIME_W-1:0]      now,
	input  wire logic                            press,
	input  wire logic                            release_bit,
	input  wire logic                            held,
	input  wire logic [bpc_pkg::TIME_W-1:0]      thr,
	output bpc_pkg::lane_status_t                status
);

	logic [bpc_pkg::TIME_W-1:0] start_q;
	logic                       fired_q;
	logic [bpc_pkg::TIME_W-1:0] start_c;
	logic [bpc_pkg::TIME_W-1:0] elapsed;
	logic                       fired_pr;
	logic                       fired_rel;
	logic                       long_c;

	always_comb begin
		start_c   = press ? now : start_q;
		fired_pr  = press ? 1'b0 : fired_q;
		fired_rel = release_bit ? 1'b0 : fired_pr;
		elapsed   = now - start_c;
		long_c    = held & ~fired_rel & (elapsed >= thr);
		status.short_hit = release_bit & ~fired_pr;
		status.long_hit  = long_c;
		status.activity  = press | release_bit | long_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			fired_q <= 1'b0;
		end else if (upd) begin
			start_q <= start_c;
			fired_q <= long_c | fired_rel;
		end
	end

endmodule

`default_nettype wire

FILE: design/bpc_merge.sv
// bpc_merge: combines lane results, tracks activity time and sleep state,
// and holds the result beat in an output register with a skid entry.
// Depends on bpc_pkg.
`default_nettype none

module bpc_merge #(
	parameter int NUM_BUTTONS = 7
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire logic [bpc_pkg::TIME_W-1:0]        now,
	input  wire bpc_pkg::lane_status_t             lane_st [NUM_BUTTONS],
	input  wire logic [bpc_pkg::TIME_W-1:0]        idle_ms,
	output logic                                   asleep,
	output logic                                   full,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [bpc_pkg::MASK_W-1:0]             short_press_mask,
	output logic [bpc_pkg::LONG_W-1:0]             long_press_mask,
	output logic                                   sleep_request,
	output logic [bpc_pkg::CAUSE_W-1:0]            sleep_cause
);

	logic [bpc_pkg::TIME_W-1:0] last_act_q;
	logic                       asleep_q;
	logic [NUM_BUTTONS-1:0]     act_v;
	logic [bpc_pkg::MASK_W-1:0] short_c;
	logic [bpc_pkg::LONG_W-1:0] long_c;
	logic [bpc_pkg::TIME_W-1:0] idle_elapsed;
	logic                       any_act;
	logic                       power_fire;
	logic                       idle_hit;
	bpc_pkg::result_t           res_c;
	bpc_pkg::result_t           out_q;
	bpc_pkg::result_t           skid_q;
	logic                       out_valid_q;
	logic                       skid_valid_q;
	logic                       pop;

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_act
		assign act_v[i] = lane_st[i].activity;
	end

	for (genvar i = 0; i < bpc_pkg::MASK_W; i++) begin : g_short
		if (i < NUM_BUTTONS) begin : g_on
			assign short_c[i] = lane_st[i].short_hit;
		end else begin : g_off
			assign short_c[i] = 1'b0;
		end
	end

	for (genvar j = 0; j < bpc_pkg::LONG_W; j++) begin : g_long
		if (j < NUM_BUTTONS - 1) begin : g_on
			assign long_c[j] = lane_st[j].long_hit;
		end else begin : g_off
			assign long_c[j] = 1'b0;
		end
	end

	always_comb begin
		any_act      = |act_v;
		power_fire   = lane_st[NUM_BUTTONS-1].long_hit;
		idle_elapsed = now - last_act_q;
		idle_hit     = ~power_fire & ~any_act & (idle_ms != '0) & (idle_elapsed >= idle_ms);
		res_c        = '0;
		if (!asleep_q) begin
			res_c.short_press_mask = short_c;
			res_c.long_press_mask  = long_c;
			res_c.sleep_request    = power_fire | idle_hit;
			if (power_fire) begin
				res_c.sleep_cause = bpc_pkg::CAUSE_POWER;
			end else if (idle_hit) begin
				res_c.sleep_cause = bpc_pkg::CAUSE_IDLE;
			end else begin
				res_c.sleep_cause = bpc_pkg::CAUSE_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_act_q <= '0;
			asleep_q   <= 1'b0;
		end else if (accept && !asleep_q) begin
			if (any_act) begin
				last_act_q <= now;
			end
			if (power_fire || idle_hit) begin
				asleep_q <= 1'b1;
			end
		end
	end

	// output register plus one skid beat
	assign pop = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (!out_valid_q || pop) begin
				out_q <= res_c;
			end else begin
				skid_q <= res_c;
			end
		end
	end

	assign asleep           = asleep_q;
	assign full             = skid_valid_q;
	assign out_valid        = out_valid_q;
	assign short_press_mask = out_q.short_press_mask;
	assign long_press_mask  = out_q.long_press_mask;
	assign sleep_request    = out_q.sleep_request;
	assign sleep_cause      = out_q.sleep_cause;

endmodule

`default_nettype wire

FILE: design/button_press_classifier.sv
// button_press_classifier: top level; configuration registers, one lane per
// button and the merge stage. Depends on bpc_pkg, bpc_lane, bpc_merge.
// Result beat lands in the output register, or the skid entry if stalled.
// One beat per cycle unless in_stall; lanes subtract, compare in parallel.
// A one-beat skid behind the output register; in_stall is high when full.
// Reset (async, active low) restores defaults; clears all but result data.
`default_nettype none

module button_press_classifier #(
	parameter int NUM_BUTTONS = 7
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bpc_pkg::TIME_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [bpc_pkg::TIME_W-1:0]        now_ms,
	input  wire logic [bpc_pkg::MASK_W-1:0]        press_edges,
	input  wire logic [bpc_pkg::MASK_W-1:0]        release_edges,
	input  wire logic [bpc_pkg::MASK_W-1:0]        held_mask,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [bpc_pkg::MASK_W-1:0]             short_press_mask,
	output logic [bpc_pkg::LONG_W-1:0]             long_press_mask,
	output logic                                   sleep_request,
	output logic [bpc_pkg::CAUSE_W-1:0]            sleep_cause
);

	logic [bpc_pkg::TIME_W-1:0] long_press_q;
	logic [bpc_pkg::TIME_W-1:0] power_hold_q;
	logic [bpc_pkg::TIME_W-1:0] idle_sleep_q;
	logic                       accept;
	logic                       asleep;
	logic                       full;
	bpc_pkg::lane_status_t      lane_st [NUM_BUTTONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= bpc_pkg::LONG_PRESS_RST;
			power_hold_q <= bpc_pkg::POWER_HOLD_RST;
			idle_sleep_q <= bpc_pkg::IDLE_SLEEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bpc_pkg::REG_LONG_PRESS: long_press_q <= cfg_data;
				bpc_pkg::REG_POWER_HOLD: power_hold_q <= cfg_data;
				bpc_pkg::REG_IDLE_SLEEP: idle_sleep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = full;
	assign accept   = in_valid & ~full;

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		logic                       press_b;
		logic                       rel_b;
		logic                       held_b;
		logic [bpc_pkg::TIME_W-1:0] thr;

		if (i < bpc_pkg::MASK_W) begin : g_in
			assign press_b = press_edges[i];
			assign rel_b   = release_edges[i];
			assign held_b  = held_mask[i];
		end else begin : g_none
			assign press_b = 1'b0;
			assign rel_b   = 1'b0;
			assign held_b  = 1'b0;
		end

		if (i == NUM_BUTTONS - 1) begin : g_pwr
			assign thr = power_hold_q;
		end else begin : g_ord
			assign thr = long_press_q;
		end

		bpc_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.upd         (accept & ~asleep),
			.now         (now_ms),
			.press       (press_b),
			.release_bit (rel_b),
			.held        (held_b),
			.thr         (thr),
			.status      (lane_st[i])
		);
	end

	bpc_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.now              (now_ms),
		.lane_st          (lane_st),
		.idle_ms          (idle_sleep_q),
		.asleep           (asleep),
		.full             (full),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.short_press_mask (short_press_mask),
		.long_press_mask  (long_press_mask),
		.sleep_request    (sleep_request),
		.sleep_cause      (sleep_cause)
	);

endmodule

`default_nettype wire

FILE: dv/bpc_scoreboard_pkg.sv
// Scoreboard for the button press classifier: a cycle-free predictor of the
// per-button short/long press and sleep logic plus a queue of expected beats.
// Depends on bpc_pkg for widths, register indexes, cause codes and result_t.
package bpc_scoreboard_pkg;

	import bpc_pkg::*;

	class press_scoreboard;
		logic [TIME_W-1:0]  long_ms;
		logic [TIME_W-1:0]  power_ms;
		logic [TIME_W-1:0]  idle_ms;
		logic [TIME_W-1:0]  start_ms [MASK_W];
		bit                 fired [MASK_W];
		logic [TIME_W-1:0]  last_act_ms;
		bit                 asleep;
		result_t            pending [$];
		int                 n_err;
		int                 n_checked;
		int                 n_short;
		int                 n_long;
		logic [CAUSE_W-1:0] last_cause;

		function new();
			clear();
		endfunction

		function void clear();
			long_ms  = LONG_PRESS_RST;
			power_ms = POWER_HOLD_RST;
			idle_ms  = IDLE_SLEEP_RST;
			foreach (start_ms[i]) begin
				start_ms[i] = '0;
				fired[i]    = 1'b0;
			end
			last_act_ms = '0;
			asleep      = 1'b0;
			pending.delete();
			n_err       = 0;
			n_checked   = 0;
			n_short     = 0;
			n_long      = 0;
			last_cause  = CAUSE_NONE;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
			case (idx)
				REG_LONG_PRESS: begin
					long_ms = data;
				end
				REG_POWER_HOLD: begin
					power_ms = data;
				end
				REG_IDLE_SLEEP: begin
					idle_ms = data;
				end
				default: begin
				end
			endcase
		endfunction

		// one accepted input beat -> one expected result beat
		function void note_beat(logic [TIME_W-1:0] now, logic [MASK_W-1:0] pe,
				logic [MASK_W-1:0] re, logic [MASK_W-1:0] hm);
			result_t           want;
			logic [TIME_W-1:0] thr;
			logic [TIME_W-1:0] elapsed;
			int                i;
			want = '0;
			if (!asleep) begin
				for (i = 0; i < MASK_W; i++) begin
					if (pe[i]) begin
						start_ms[i] = now;
						fired[i]    = 1'b0;
						last_act_ms = now;
					end
					if (re[i]) begin
						last_act_ms = now;
						if (!fired[i]) begin
							want.short_press_mask[i] = 1'b1;
						end
						fired[i] = 1'b0;
					end
					if (hm[i] && !fired[i]) begin
						thr     = (i == MASK_W - 1) ? power_ms : long_ms;
						elapsed = now - start_ms[i];
						if (elapsed >= thr) begin
							fired[i]    = 1'b1;
							last_act_ms = now;
							if (i == MASK_W - 1) begin
								want.sleep_request = 1'b1;
								want.sleep_cause   = CAUSE_POWER;
								asleep             = 1'b1;
								break;
							end
							want.long_press_mask[i] = 1'b1;
						end
					end
				end
				elapsed = now - last_act_ms;
				if (!asleep && idle_ms != '0 && elapsed >= idle_ms) begin
					want.sleep_request = 1'b1;
					want.sleep_cause   = CAUSE_IDLE;
					asleep             = 1'b1;
				end
			end
			pending.push_back(want);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				n_err++;
				return;
			end
			want = pending.pop_front();
			n_checked++;
			n_short += $countones(want.short_press_mask);
			n_long  += $countones(want.long_press_mask);
			if (want.sleep_request) begin
				last_cause = want.sleep_cause;
			end
			if (got.short_press_mask !== want.short_press_mask) begin
				$error("short_press_mask: expected %h, got %h",
					want.short_press_mask, got.short_press_mask);
				n_err++;
			end
			if (got.long_press_mask !== want.long_press_mask) begin
				$error("long_press_mask: expected %h, got %h",
					want.long_press_mask, got.long_press_mask);
				n_err++;
			end
			if (got.sleep_request !== want.sleep_request) begin
				$error("sleep_request: expected %b, got %b",
					want.sleep_request, got.sleep_request);
				n_err++;
			end
			if (got.sleep_cause !== want.sleep_cause) begin
				$error("sleep_cause: expected %0d, got %0d",
					want.sleep_cause, got.sleep_cause);
				n_err++;
			end
		endfunction
	endclass

endpackage

FILE: dv/button_press_classifier_tb.sv
// Testbench top for button_press_classifier: directed ticks, then phases of
// random button activity under several register settings, ending in sleep.
// Depends on bpc_pkg, bpc_scoreboard_pkg and the button_press_classifier RTL.
module button_press_classifier_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import bpc_pkg::*;
	import bpc_scoreboard_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [TIME_W-1:0]    ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [MASK_W-1:0]    ALL_BTNS   = 7'h7F;
	localparam logic [MASK_W-1:0]    ORDINARY   = 7'h3F;
	localparam logic [MASK_W-1:0]    POWER_BTN  = 7'h40;
	localparam int                   CYCLE_LIMIT = 400_000;
	localparam int                   LONG_HOLD   = 300;
	localparam int                   HOLD_AFTER  = 600;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIME_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [TIME_W-1:0]    now_ms;
	logic [MASK_W-1:0]    press_edges;
	logic [MASK_W-1:0]    release_edges;
	logic [MASK_W-1:0]    held_mask;
	logic                 out_valid;
	logic                 out_stall;
	logic [MASK_W-1:0]    short_press_mask;
	logic [LONG_W-1:0]    long_press_mask;
	logic                 sleep_request;
	logic [CAUSE_W-1:0]   sleep_cause;

	press_scoreboard   sb = new;
	result_t           seen_beat;
	int                cycles = 0;
	int                send_idle_pct = 30;
	int                recv_stall_pct = 30;
	bit                long_hold_done = 1'b0;
	logic [TIME_W-1:0] cur_ms = '0;
	logic [MASK_W-1:0] btn_down = '0;
	logic [MASK_W-1:0] btn_enable = ALL_BTNS;

	button_press_classifier #(
		.NUM_BUTTONS(MASK_W)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.now_ms           (now_ms),
		.press_edges      (press_edges),
		.release_edges    (release_edges),
		.held_mask        (held_mask),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.short_press_mask (short_press_mask),
		.long_press_mask  (long_press_mask),
		.sleep_request    (sleep_request),
		.sleep_cause      (sleep_cause)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL button_press_classifier");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_beat(now_ms, press_edges, release_edges, held_mask);
			end
			if (out_valid && !out_stall) begin
				seen_beat.short_press_mask = short_press_mask;
				seen_beat.long_press_mask  = long_press_mask;
				seen_beat.sleep_request    = sleep_request;
				seen_beat.sleep_cause      = sleep_cause;
				sb.check_result(seen_beat);
			end
		end
	end

	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct) begin
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			return int'($urandom_range(10, 40));
		end
		return int'($urandom_range(1, 3));
	endfunction

	// result side: random stalls, plus one long hold-off while beats pile up
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && sb.n_checked >= HOLD_AFTER) begin
				n = LONG_HOLD;
				long_hold_done = 1'b1;
			end else begin
				n = pick_gap(recv_stall_pct);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	task automatic send_beat(logic [TIME_W-1:0] now, logic [MASK_W-1:0] pe,
			logic [MASK_W-1:0] re, logic [MASK_W-1:0] hm);
		int gap;
		gap = pick_gap(send_idle_pct);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		now_ms        <= now;
		press_edges   <= pe;
		release_edges <= re;
		held_mask     <= hm;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [TIME_W-1:0] long_v, logic [TIME_W-1:0] power_v,
			logic [TIME_W-1:0] idle_v);
		drain();
		cfg_write(REG_LONG_PRESS, long_v);
		cfg_write(REG_POWER_HOLD, power_v);
		cfg_write(REG_IDLE_SLEEP, idle_v);
	endtask

	// mostly a consistent press/hold/release model, some raw noise
	task automatic random_beat(int noise_pct);
		logic [MASK_W-1:0] pe;
		logic [MASK_W-1:0] re;
		logic [MASK_W-1:0] hm;
		int                r;
		int                i;
		pe = '0;
		re = '0;
		r  = $urandom_range(0, 99);
		if (r < 2) begin
			cur_ms = $urandom;
		end else if (r < 4) begin
			cur_ms = ALL_ONES - $urandom_range(0, 200);
		end else if (r < 10) begin
			cur_ms = cur_ms + $urandom_range(0, 5000);
		end else begin
			cur_ms = cur_ms + $urandom_range(0, 40);
		end
		if ($urandom_range(0, 99) < noise_pct) begin
			pe = MASK_W'($urandom_range(0, 127));
			re = MASK_W'($urandom_range(0, 127));
			hm = MASK_W'($urandom_range(0, 127));
		end else begin
			for (i = 0; i < MASK_W; i++) begin
				if (btn_down[i]) begin
					if ($urandom_range(0, 99) < 10) begin
						re[i]       = 1'b1;
						btn_down[i] = 1'b0;
					end
				end else if ($urandom_range(0, 99) < 15) begin
					pe[i]       = 1'b1;
					btn_down[i] = 1'b1;
				end
			end
			hm = btn_down;
		end
		send_beat(cur_ms, pe & btn_enable, re & btn_enable, hm & btn_enable);
	endtask

	task automatic run_phase(int count, int noise_pct);
		int n;
		for (n = 0; n < count; n++) begin
			if (n == count / 2) begin
				drain();
			end
			random_beat(noise_pct);
		end
	endtask

	initial begin
		logic [TIME_W-1:0] thr;
		logic [MASK_W-1:0] rel;
		int                k;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_LONG_PRESS;
		cfg_data      = '0;
		in_valid      = 1'b0;
		now_ms        = '0;
		press_edges   = '0;
		release_edges = '0;
		held_mask     = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset thresholds; a write to the spare index must change nothing
		cfg_write(REG_UNUSED, ALL_ONES);
		send_beat(32'd0, '0, '0, '0);
		send_beat(32'd100, ALL_BTNS, '0, ALL_BTNS);
		send_beat(32'd1099, '0, '0, ALL_BTNS);
		send_beat(32'd1100, '0, '0, ALL_BTNS);
		send_beat(32'd3099, '0, '0, ORDINARY);
		send_beat(32'd3200, '0, ALL_BTNS, '0);
		send_beat(32'd4000, 7'h01, '0, 7'h01);
		send_beat(32'd5000, '0, '0, 7'h01);
		// release and hold in one tick re-arms and fires again
		send_beat(32'd6000, '0, 7'h01, 7'h01);
		send_beat(32'd6001, '0, 7'h01, '0);
		send_beat(ALL_ONES, '0, '0, ORDINARY);
		// elapsed time across the timestamp wrap
		send_beat(32'hFFFF_FF00, 7'h02, '0, 7'h02);
		send_beat(32'h0000_0010, '0, '0, 7'h02);
		send_beat(32'h0000_03F0, '0, '0, 7'h02);
		send_beat(32'h0000_0400, '0, 7'h02, '0);
		send_beat(32'h0000_0500, POWER_BTN, '0, POWER_BTN);
		send_beat(32'h0000_0600, '0, POWER_BTN, '0);
		send_beat(32'h0000_0700, ALL_BTNS, ALL_BTNS, ALL_BTNS);
		cur_ms = 32'h0000_1000;

		send_idle_pct  = 30;
		recv_stall_pct = 30;
		configure(32'd50, ALL_ONES, 32'd0);
		run_phase(250, 10);

		send_idle_pct  = 20;
		recv_stall_pct = 50;
		configure(32'd0, ALL_ONES, ALL_ONES);
		run_phase(150, 10);

		// power button kept quiet while its hold time is zero
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		btn_enable     = ORDINARY;
		configure(ALL_ONES, 32'd0, 32'd0);
		run_phase(100, 10);
		btn_enable     = ALL_BTNS;

		send_idle_pct  = 10;
		recv_stall_pct = 20;
		configure($urandom_range(1, 300), ALL_ONES, 32'd0);
		run_phase(350, 10);

		// one sleep per reset: the seed picks the cause
		send_idle_pct  = 30;
		recv_stall_pct = 30;
		if ($urandom_range(0, 1) == 1) begin
			thr = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 200);
			configure(($urandom_range(0, 1) == 1) ? thr : 32'd20, thr,
				($urandom_range(0, 1) == 1) ? ALL_ONES : 32'd0);
			send_beat(cur_ms, ALL_BTNS, '0, ALL_BTNS);
			for (k = 0; k < 40; k++) begin
				cur_ms = cur_ms + 32'd10;
				rel    = MASK_W'($urandom_range(0, 63));
				send_beat(cur_ms, '0, rel, POWER_BTN | (ORDINARY & ~rel));
			end
		end else begin
			configure(32'd20, ALL_ONES, $urandom_range(1, 300));
			for (k = 0; k < 40; k++) begin
				cur_ms = cur_ms + 32'd25;
				send_beat(cur_ms, '0, '0, '0);
			end
		end
		run_phase(20, 100);

		drain();
		repeat (4) @(posedge clk);
		$display("%0d beats checked: %0d short-press bits, %0d long-press bits, ended in %s",
			sb.n_checked, sb.n_short, sb.n_long,
			(sb.last_cause == CAUSE_POWER) ? "power-hold sleep" :
			(sb.last_cause == CAUSE_IDLE) ? "inactivity sleep" : "no sleep");
		if (sb.n_err == 0) begin
			$display("PASS button_press_classifier");
		end else begin
			$display("FAIL button_press_classifier");
		end
		$finish;
	end

endmodule
